FILE: hw/rtl/sobel_edge_magnitude_macros.svh
// Assertion helpers
`ifndef SOBEL_EDGE_MAGNITUDE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_MACROS_SVH
`define SEM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SEM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

FILE: hw/rtl/sem_pkg.sv
package sem_pkg;
   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int PIXEL_BITS_DEF = 8;
   localparam int MAX_HEIGHT     = 4096;
   localparam int MAG_MAX        = 1023;
   localparam int SCALE_NUM      = 363;
   localparam int SCALE_SHIFT    = 9;
   localparam int QUEUE_DEPTH    = 4;
   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_HEN    = 2'd2;
   localparam logic [1:0] REG_VEN    = 2'd3;

   typedef struct packed {
      logic signed [13:0] gx;
      logic signed [13:0] gy;
      logic               both;
      logic               last;
   } grad_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_ROOT = 3'b010,
      ST_DONE = 3'b100
   } back_state_type;
endpackage

FILE: hw/rtl/sem_front.sv
module sem_front #(
   parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
   parameter int PIXEL_BITS = sem_pkg::PIXEL_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        pixel,
   input  logic              frame_start,
   input  logic [11:0]       frame_width,
   input  logic [12:0]       frame_height,
   input  logic              hen,
   input  logic              ven,
   output logic              q_valid,
   input  logic              q_ready,
   output sem_pkg::grad_type q_data
);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = CW + 1;
   localparam int PB = (PIXEL_BITS < 8) ? PIXEL_BITS : 8;

   logic [7:0] above_mem [MAX_WIDTH];
   logic [7:0] middle_mem [MAX_WIDTH];
   logic [7:0] win_ff [6];
   logic [7:0] win_in [6];
   logic [CW-1:0] col_ff, col_in;
   logic [12:0] row_ff, row_in;
   logic [WW-1:0] w_used;
   logic [13:0] h_used;
   logic [7:0] px, top_ff, mid_ff;
   logic [CW-1:0] c, cr;
   logic [12:0] r;
   logic stage_ff, stage_in;
   logic [7:0] spx_ff;
   logic [CW-1:0] sc_ff;
   logic [12:0] sr_ff;
   logic adv;

   always_comb begin
      if (frame_width < 12'd3) w_used = WW'(3);
      else if (32'(frame_width) > MAX_WIDTH) w_used = WW'(MAX_WIDTH);
      else w_used = WW'(frame_width);
      if (frame_height < 13'd3) h_used = 14'd3;
      else if ({1'b0, frame_height} > 14'(sem_pkg::MAX_HEIGHT))
         h_used = 14'(sem_pkg::MAX_HEIGHT);
      else h_used = {1'b0, frame_height};
   end

   // stage 0 computes address, stage 1 reads memory output
   assign in_ready = !stage_ff || adv;
   assign px = pixel & 8'((1 << PB) - 1);
   always_comb begin
      c = frame_start ? '0 : col_ff;
      r = frame_start ? '0 : row_ff;
      if ({1'b0, c} >= w_used) cr = CW'(w_used - 1'b1);
      else cr = c;
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         top_ff <= above_mem[cr];
         mid_ff <= middle_mem[cr];
         spx_ff <= px;
         sc_ff <= cr;
         sr_ff <= r;
      end
   end

   logic interior;
   logic signed [13:0] gx, gy;
   logic signed [13:0] tl, ml, bl, tc, bc, tr, mr, br;
   always_comb begin
      tl = 14'(win_ff[0]); ml = 14'(win_ff[1]); bl = 14'(win_ff[2]);
      tc = 14'(win_ff[3]); bc = 14'(win_ff[5]);
      tr = 14'(top_ff); mr = 14'(mid_ff); br = 14'(spx_ff);
      gx = hen ? (tr + 14'sd2 * mr + br) - (tl + 14'sd2 * ml + bl) : 14'sd0;
      gy = ven ? (bl + 14'sd2 * bc + br) - (tl + 14'sd2 * tc + tr) : 14'sd0;
      interior = (sr_ff >= 13'd2) && (sc_ff >= CW'(2));
      q_valid = stage_ff && interior;
      q_data.gx = gx;
      q_data.gy = gy;
      q_data.both = hen && ven;
      q_data.last = ({1'b0, sr_ff} >= h_used - 1'b1) &&
                    ({1'b0, sc_ff} >= w_used - 1'b1);
      adv = stage_ff && (!interior || q_ready);
      stage_in = (in_valid && in_ready) || (stage_ff && !adv);
      win_in = win_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (in_valid && in_ready) begin
         if ({1'b0, cr} >= w_used - 1'b1) begin
            col_in = '0;
            row_in = ({1'b0, r} >= h_used - 1'b1) ? '0 : r + 1'b1;
         end else begin
            col_in = cr + 1'b1;
            row_in = ({1'b0, r} >= h_used) ? 13'(h_used - 1'b1) : r;
         end
      end
      if (adv) begin
         win_in[0] = win_ff[3]; win_in[1] = win_ff[4]; win_in[2] = win_ff[5];
         win_in[3] = top_ff; win_in[4] = mid_ff; win_in[5] = spx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         above_mem[sc_ff] <= mid_ff;
         middle_mem[sc_ff] <= spx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         col_ff <= '0;
         row_ff <= '0;
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else begin
         stage_ff <= stage_in;
         col_ff <= col_in;
         row_ff <= row_in;
         win_ff <= win_in;
      end
   end
endmodule

FILE: hw/rtl/sem_queue.sv
module sem_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  sem_pkg::grad_type wr_data,
   output logic              rd_valid,
   input  logic              rd_ready,
   output sem_pkg::grad_type rd_data
);
   localparam int D = sem_pkg::QUEUE_DEPTH;
   localparam int AW = $clog2(D);
   sem_pkg::grad_type mem_ff [D];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0] cnt_ff;
   logic wr, rd;
   assign wr_ready = cnt_ff != (AW+1)'(D);
   assign rd_valid = cnt_ff != '0;
   assign rd_data = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;
   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wr_data;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + 1'b1;
         if (rd) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(wr) - (AW+1)'(rd);
      end
   end
endmodule

FILE: hw/rtl/sem_back.sv
module sem_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  sem_pkg::grad_type q_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [9:0]        magnitude,
   output logic              frame_last
);
   sem_pkg::back_state_type st_ff, st_in;
   logic [3:0] it_ff, it_in;
   logic [9:0] mag_ff, mag_in;
   logic last_ff, last_in;
   logic [12:0] res_ff;
   logic [27:0] rad_ff, part_ff;
   logic [27:0] part_sh, tv;
   logic [25:0] rad_in;
   logic [13:0] ax, ay, as;
   logic signed [14:0] t;
   logic [21:0] scaled;
   logic step;

   assign q_ready = st_ff == sem_pkg::ST_IDLE;
   assign out_valid = st_ff == sem_pkg::ST_DONE;
   assign magnitude = mag_ff;
   assign frame_last = last_ff;
   assign step = (st_ff == sem_pkg::ST_ROOT) && (it_ff != 4'd13);

   always_comb begin
      st_in = st_ff; it_in = it_ff;
      mag_in = mag_ff; last_in = last_ff;
      ax = q_data.gx[13] ? 14'(-q_data.gx) : q_data.gx;
      ay = q_data.gy[13] ? 14'(-q_data.gy) : q_data.gy;
      t = 15'(q_data.gx) + 15'(q_data.gy);
      as = t[14] ? 14'(-t) : t[13:0];
      rad_in = 26'(ax) * 26'(ax) + 26'(ay) * 26'(ay);
      part_sh = {part_ff[25:0], rad_ff[27:26]};
      tv = {13'd0, res_ff, 2'b01};
      scaled = 22'(res_ff) * 22'(sem_pkg::SCALE_NUM);
      case (st_ff)
         sem_pkg::ST_IDLE: begin
            if (q_valid) begin
               last_in = q_data.last;
               if (q_data.both) begin
                  it_in = '0;
                  st_in = sem_pkg::ST_ROOT;
               end else begin
                  mag_in = (as > 14'(sem_pkg::MAG_MAX)) ? 10'(sem_pkg::MAG_MAX) : as[9:0];
                  st_in = sem_pkg::ST_DONE;
               end
            end
         end
         sem_pkg::ST_ROOT: begin
            // 13 steps, two radicand bits per step MSB first
            if (it_ff == 4'd13) begin
               mag_in = (scaled[21:9] > 13'(sem_pkg::MAG_MAX)) ?
                        10'(sem_pkg::MAG_MAX) : scaled[18:9];
               st_in = sem_pkg::ST_DONE;
            end else it_in = it_ff + 1'b1;
         end
         sem_pkg::ST_DONE: if (out_ready) st_in = sem_pkg::ST_IDLE;
         default: st_in = sem_pkg::ST_IDLE;
      endcase
   end

   // digit-by-digit root
   always_ff @(posedge clock) begin
      if (st_ff == sem_pkg::ST_IDLE) begin
         rad_ff <= {rad_in, 2'b00};
         part_ff <= '0;
         res_ff <= '0;
      end else if (step) begin
         rad_ff <= {rad_ff[25:0], 2'b00};
         part_ff <= (part_sh >= tv) ? part_sh - tv : part_sh;
         res_ff <= {res_ff[11:0], part_sh >= tv};
      end
      mag_ff <= mag_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= sem_pkg::ST_IDLE;
         it_ff <= '0;
      end else begin
         st_ff <= st_in;
         it_ff <= it_in;
      end
   end
endmodule

FILE: hw/rtl/sobel_edge_magnitude.sv
// Path: pixel into the front window stage, then the gradient queue, then the back end;
// with both directions the back end runs a 13-step square root.
// Throughput: one pixel per cycle while the 4-entry queue has room; the back end
// takes a new gradient only once its last result has been taken from its output.
// Reset: synchronous active high; counters, window and registers to defaults,
// line stores undefined until written.
`include "sobel_edge_magnitude_macros.svh"
module sobel_edge_magnitude #(
   parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
   parameter int PIXEL_BITS = sem_pkg::PIXEL_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_pixel,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_magnitude,
   output logic        rsp_frame_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   logic [11:0] fw_ff;
   logic [12:0] fh_ff;
   logic hen_ff, ven_ff;
   logic [1:0] idx;
   logic wr;
   assign pready = 1'b1;
   assign idx = paddr[3:2];
   assign wr = psel && penable && pwrite && pready;
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= 12'd640; fh_ff <= 13'd480; hen_ff <= 1'b1; ven_ff <= 1'b1;
      end else if (wr) begin
         case (idx)
            sem_pkg::REG_WIDTH:  fw_ff <= pwdata[11:0];
            sem_pkg::REG_HEIGHT: fh_ff <= pwdata[12:0];
            sem_pkg::REG_HEN:    hen_ff <= pwdata[0];
            sem_pkg::REG_VEN:    ven_ff <= pwdata[0];
            default: ;
         endcase
      end
   end
   always_comb begin
      case (idx)
         sem_pkg::REG_WIDTH:  prdata = {20'd0, fw_ff};
         sem_pkg::REG_HEIGHT: prdata = {19'd0, fh_ff};
         sem_pkg::REG_HEN:    prdata = {31'd0, hen_ff};
         sem_pkg::REG_VEN:    prdata = {31'd0, ven_ff};
         default: prdata = '0;
      endcase
   end

   logic fq_valid, fq_ready, bq_valid, bq_ready;
   sem_pkg::grad_type fq_data, bq_data;

   sem_front #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_front (
      .clock, .reset, .in_valid(req_valid), .in_ready(req_ready),
      .pixel(req_pixel), .frame_start(req_frame_start),
      .frame_width(fw_ff), .frame_height(fh_ff), .hen(hen_ff), .ven(ven_ff),
      .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data));
   sem_queue u_queue (
      .clock, .reset, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
      .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data));
   sem_back u_back (
      .clock, .reset, .q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .magnitude(rsp_magnitude), .frame_last(rsp_frame_last));

   `SEM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_magnitude))
   `SEM_ASSERT_IMPL(a_back_busy, clock, reset, rsp_valid, !bq_ready)
   `SEM_ASSERT_IMPL(a_queue_full, clock, reset, fq_valid && !fq_ready, bq_valid)
endmodule
